// ===== hw/rtl/bls_pkg.sv =====
package bls_pkg;

	localparam int OP_W  = 3;
	localparam int POS_W = 8;
	localparam int VAL_W = 32;
	localparam int ST_W  = 2;

	typedef enum logic [OP_W-1:0] {
		OP_APPEND = 3'd0,
		OP_REMOVE = 3'd1,
		OP_INSERT = 3'd2,
		OP_ERASE  = 3'd3,
		OP_READ   = 3'd4,
		OP_CLEAR  = 3'd5
	} op_t;

	typedef enum logic [ST_W-1:0] {
		ST_OK    = 2'd0,
		ST_RANGE = 2'd1,
		ST_FULL  = 2'd2,
		ST_EMPTY = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_SHIFT,
		S_PUT,
		S_DONE
	} state_t;

endpackage

// ===== hw/rtl/bls_if.sv =====
interface bls_req_if import bls_pkg::*; ;
	logic                    valid;
	logic                    ready;
	logic [OP_W-1:0]         operation;
	logic signed [POS_W-1:0] position;
	logic signed [VAL_W-1:0] value;

	modport source(output valid, operation, position, value, input ready);
	modport sink(input valid, operation, position, value, output ready);
endinterface

interface bls_rsp_if import bls_pkg::*; #(parameter int CNT_W = 7);
	logic                    valid;
	logic                    ready;
	logic signed [VAL_W-1:0] read_value;
	logic [ST_W-1:0]         status;
	logic [CNT_W-1:0]        count;

	modport source(output valid, read_value, status, count, input ready);
	modport sink(input valid, read_value, status, count, output ready);
endinterface

// ===== hw/rtl/bls_mem.sv =====
module bls_mem import bls_pkg::*; #(
	parameter int DEPTH = 64,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [VAL_W-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [VAL_W-1:0] rdata
);

	logic [VAL_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== hw/rtl/bls_ctrl.sv =====
module bls_ctrl import bls_pkg::*; #(
	parameter int DEPTH = 64,
	localparam int AW = $clog2(DEPTH),
	localparam int CW = $clog2(DEPTH + 1)
) (
	input  logic             clk,
	input  logic             arst_n,
	bls_req_if.sink          req,
	bls_rsp_if.source        rsp,
	output logic             mem_we,
	output logic [AW-1:0]    mem_waddr,
	output logic [VAL_W-1:0] mem_wdata,
	output logic             mem_re,
	output logic [AW-1:0]    mem_raddr,
	input  logic [VAL_W-1:0] mem_rdata
);

	localparam int XW = ((CW > POS_W) ? CW : POS_W) + 1;

	state_t                  state_q, state_d;
	logic [OP_W-1:0]         op_q, op_d;
	logic signed [POS_W-1:0] pos_q, pos_d;
	logic [VAL_W-1:0]        val_q, val_d;
	logic [CW-1:0]           count_q, count_d;
	status_t                 status_q, status_d;
	logic                    take_rd_q, take_rd_d;
	logic [AW-1:0]           ptr_q, ptr_d;
	logic [AW-1:0]           end_q, end_d;
	logic [AW-1:0]           wa_q, wa_d;
	logic                    up_q, up_d;
	logic                    more_q, more_d;
	logic                    wpend_q, wpend_d;
	logic                    out_valid_q, out_valid_d;
	logic [VAL_W-1:0]        out_rd_q, out_rd_d;
	status_t                 out_st_q, out_st_d;
	logic [CW-1:0]           out_cnt_q, out_cnt_d;

	logic signed [XW-1:0] pos_x, n_x, rel_x;
	logic                 empty, full, ins_bad, idx_bad, rd_bad;
	logic [AW-1:0]        pos_a, cnt_a, n_m1, rel_a;

	assign pos_x   = XW'(pos_q);
	assign n_x     = signed'({{(XW - CW){1'b0}}, count_q});
	assign rel_x   = (pos_x < 0) ? (n_x + pos_x) : pos_x;
	assign empty   = (count_q == '0);
	assign full    = (count_q == CW'(DEPTH));
	assign ins_bad = (pos_x < 0) || (pos_x > n_x);
	assign idx_bad = (pos_x < 0) || (pos_x >= n_x);
	assign rd_bad  = (rel_x < 0) || (rel_x >= n_x);
	assign pos_a   = AW'(pos_q);
	assign cnt_a   = AW'(count_q);
	assign n_m1    = AW'(count_q - CW'(1));
	assign rel_a   = AW'(rel_x);

	assign req.ready      = (state_q == S_IDLE);
	assign rsp.valid      = out_valid_q;
	assign rsp.read_value = out_rd_q;
	assign rsp.status     = out_st_q;
	assign rsp.count      = out_cnt_q;

	always_comb begin
		state_d     = state_q;
		op_d        = op_q;
		pos_d       = pos_q;
		val_d       = val_q;
		count_d     = count_q;
		status_d    = status_q;
		take_rd_d   = take_rd_q;
		ptr_d       = ptr_q;
		end_d       = end_q;
		wa_d        = wa_q;
		up_d        = up_q;
		more_d      = more_q;
		wpend_d     = wpend_q;
		out_valid_d = out_valid_q && !rsp.ready;
		out_rd_d    = out_rd_q;
		out_st_d    = out_st_q;
		out_cnt_d   = out_cnt_q;
		mem_we      = 1'b0;
		mem_waddr   = '0;
		mem_wdata   = val_q;
		mem_re      = 1'b0;
		mem_raddr   = '0;

		unique case (state_q)
			S_IDLE: begin
				if (req.valid) begin
					op_d    = req.operation;
					pos_d   = req.position;
					val_d   = req.value;
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				status_d  = ST_OK;
				take_rd_d = 1'b0;
				state_d   = S_DONE;
				unique case (op_q)
					OP_APPEND: begin
						if (full) begin
							status_d = ST_FULL;
						end else begin
							mem_we    = 1'b1;
							mem_waddr = cnt_a;
							count_d   = count_q + CW'(1);
						end
					end
					OP_REMOVE: begin
						if (empty) begin
							status_d = ST_EMPTY;
						end else begin
							mem_re    = 1'b1;
							mem_raddr = n_m1;
							take_rd_d = 1'b1;
							count_d   = count_q - CW'(1);
						end
					end
					OP_INSERT: begin
						if (ins_bad) begin
							status_d = ST_RANGE;
						end else if (full) begin
							status_d = ST_FULL;
						end else begin
							count_d = count_q + CW'(1);
							if (pos_x == n_x) begin
								mem_we    = 1'b1;
								mem_waddr = pos_a;
							end else begin
								ptr_d   = n_m1;
								end_d   = pos_a;
								up_d    = 1'b1;
								more_d  = 1'b1;
								wpend_d = 1'b0;
								state_d = S_SHIFT;
							end
						end
					end
					OP_ERASE: begin
						if (empty) begin
							status_d = ST_EMPTY;
						end else if (idx_bad) begin
							status_d = ST_RANGE;
						end else begin
							count_d = count_q - CW'(1);
							if (pos_x != n_x - XW'(1)) begin
								ptr_d   = pos_a + AW'(1);
								end_d   = n_m1;
								up_d    = 1'b0;
								more_d  = 1'b1;
								wpend_d = 1'b0;
								state_d = S_SHIFT;
							end
						end
					end
					OP_READ: begin
						if (empty) begin
							status_d = ST_EMPTY;
						end else if (rd_bad) begin
							status_d = ST_RANGE;
						end else begin
							mem_re    = 1'b1;
							mem_raddr = rel_a;
							take_rd_d = 1'b1;
						end
					end
					OP_CLEAR: begin
						count_d = '0;
					end
					default: begin
					end
				endcase
			end
			S_SHIFT: begin
				// write back last cycle's read while reading the next entry
				mem_we    = wpend_q;
				mem_waddr = wa_q;
				mem_wdata = mem_rdata;
				if (more_q) begin
					mem_re    = 1'b1;
					mem_raddr = ptr_q;
					wa_d      = up_q ? (ptr_q + AW'(1)) : (ptr_q - AW'(1));
					wpend_d   = 1'b1;
					ptr_d     = up_q ? (ptr_q - AW'(1)) : (ptr_q + AW'(1));
					more_d    = (ptr_q != end_q);
				end else begin
					wpend_d = 1'b0;
					state_d = up_q ? S_PUT : S_DONE;
				end
			end
			S_PUT: begin
				mem_we    = 1'b1;
				mem_waddr = end_q;
				state_d   = S_DONE;
			end
			S_DONE: begin
				if (!out_valid_q || rsp.ready) begin
					out_valid_d = 1'b1;
					out_rd_d    = take_rd_q ? mem_rdata : '0;
					out_st_d    = status_q;
					out_cnt_d   = count_q;
					state_d     = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			more_q      <= 1'b0;
			wpend_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			count_q     <= count_d;
			more_q      <= more_d;
			wpend_q     <= wpend_d;
			out_valid_q <= out_valid_d;
		end
	end

	always_ff @(posedge clk) begin
		op_q      <= op_d;
		pos_q     <= pos_d;
		val_q     <= val_d;
		status_q  <= status_d;
		take_rd_q <= take_rd_d;
		ptr_q     <= ptr_d;
		end_q     <= end_d;
		wa_q      <= wa_d;
		up_q      <= up_d;
		out_rd_q  <= out_rd_d;
		out_st_q  <= out_st_d;
		out_cnt_q <= out_cnt_d;
	end

endmodule

// ===== hw/rtl/bounded_list_store_unit.sv =====
// channel | dir | transfer carries
// req     | in  | operation, position, value
// rsp     | out | read_value, status, count
//
// One item at a time. Append, remove, read, clear, rejected items and an insert
// or erase with nothing to shift go from the EXEC state to the DONE state, which
// loads the result register once it is free. Insert and erase shift k > 0 entries
// through the entry RAM's read and write ports in the SHIFT state, one entry a
// cycle; an insert then writes its value in the PUT state before DONE.
// Reset empties the list at once; the entry RAM is not cleared.
// A stalled rsp holds the finished result; the next req is taken meanwhile.
module bounded_list_store_unit import bls_pkg::*; #(
	parameter int DEPTH = 64
) (
	input  logic      clk,
	input  logic      arst_n,
	bls_req_if.sink   req,
	bls_rsp_if.source rsp
);

	localparam int AW = $clog2(DEPTH);

	logic             mem_we;
	logic [AW-1:0]    mem_waddr;
	logic [VAL_W-1:0] mem_wdata;
	logic             mem_re;
	logic [AW-1:0]    mem_raddr;
	logic [VAL_W-1:0] mem_rdata;

	bls_ctrl #(.DEPTH(DEPTH)) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.rsp       (rsp),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata),
		.mem_re    (mem_re),
		.mem_raddr (mem_raddr),
		.mem_rdata (mem_rdata)
	);

	bls_mem #(.DEPTH(DEPTH)) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

endmodule

// ===== hw/rtl/bls_chk.sv =====
module bls_chk import bls_pkg::*; #(
	parameter int DEPTH = 64,
	localparam int CW = $clog2(DEPTH + 1)
) (
	input logic             clk,
	input logic             arst_n,
	input logic             rsp_valid,
	input logic             rsp_ready,
	input logic [VAL_W-1:0] read_value,
	input logic [ST_W-1:0]  status,
	input logic [CW-1:0]    count
);

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (count <= CW'(DEPTH)))
		else $error("count above capacity");

	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && (status == ST_FULL)) |-> (count == CW'(DEPTH)))
		else $error("full status with room left");

	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && (status == ST_EMPTY)) |-> ((count == '0) && (read_value == '0)))
		else $error("empty status on nonempty list or with data");

	a_range_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && (status == ST_RANGE)) |-> (read_value == '0))
		else $error("range error returned data");

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(count) && $stable(status)))
		else $error("stalled result changed");

endmodule

bind bounded_list_store_unit bls_chk #(.DEPTH(DEPTH)) u_bls_chk (
	.clk        (clk),
	.arst_n     (arst_n),
	.rsp_valid  (rsp.valid),
	.rsp_ready  (rsp.ready),
	.read_value (rsp.read_value),
	.status     (rsp.status),
	.count      (rsp.count)
);

// ===== verif/tb.sv =====
module tb;
	import bls_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int DEPTH       = 64;
	localparam int CNT_W       = 7;
	localparam int N_RANDOM    = 1060;
	localparam int LONG_HOLD   = 300;
	localparam int QUIET_LIMIT = 2000;
	localparam int MAX_REPORTS = 50;

	localparam logic [OP_W-1:0] OP_UNUSED_LO = 3'd6;
	localparam logic [OP_W-1:0] OP_UNUSED_HI = 3'd7;

	typedef enum int {MODE_GROW, MODE_SHRINK, MODE_MIXED} fill_mode_t;

	typedef struct packed {
		logic signed [VAL_W-1:0] read_value;
		logic [ST_W-1:0]         status;
		logic [CNT_W-1:0]        count;
	} list_result_t;

	typedef struct {
		logic [OP_W-1:0]         op;
		logic signed [POS_W-1:0] pos;
		logic signed [VAL_W-1:0] val;
		int                      reps;
		bit                      typed;
		list_result_t            res;
	} dir_row_t;

	logic clk = 1'b0;
	logic arst_n;

	bls_req_if                 req_if();
	bls_rsp_if #(.CNT_W(CNT_W)) rsp_if();

	bounded_list_store_unit #(.DEPTH(DEPTH)) i_dut (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req_if),
		.rsp   (rsp_if)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	logic signed [VAL_W-1:0] list_vals[$];
	list_result_t            result_q[$];
	list_result_t            exp_res;

	int err_cnt     = 0;
	int n_sent      = 0;
	int n_checked   = 0;
	int peak_fill   = 0;
	int status_hits[4];
	int quiet_cycles = 0;
	int burst_left  = 0;
	bit no_idle     = 1'b0;
	bit hold_long   = 1'b0;

	// Applies one operation to the list copy and returns its result.
	function automatic list_result_t apply_list_op(logic [OP_W-1:0] op,
			logic signed [POS_W-1:0] pos, logic signed [VAL_W-1:0] val);
		list_result_t r;
		int n;
		int p;
		r = '0;
		n = list_vals.size();
		p = pos;
		case (op)
			OP_APPEND: begin
				if (n >= DEPTH) r.status = ST_FULL;
				else list_vals.push_back(val);
			end
			OP_REMOVE: begin
				if (n == 0) r.status = ST_EMPTY;
				else r.read_value = list_vals.pop_back();
			end
			OP_INSERT: begin
				if (p < 0 || p > n) r.status = ST_RANGE;
				else if (n >= DEPTH) r.status = ST_FULL;
				else list_vals.insert(p, val);
			end
			OP_ERASE: begin
				if (n == 0) r.status = ST_EMPTY;
				else if (p < 0 || p >= n) r.status = ST_RANGE;
				else list_vals.delete(p);
			end
			OP_READ: begin
				if (n == 0) begin
					r.status = ST_EMPTY;
				end else begin
					if (p < 0) p = n + p;
					if (p < 0 || p >= n) r.status = ST_RANGE;
					else r.read_value = list_vals[p];
				end
			end
			OP_CLEAR: begin
				list_vals.delete();
			end
			default: begin
			end
		endcase
		r.count = CNT_W'(list_vals.size());
		return r;
	endfunction

	function automatic dir_row_t step_row(logic [OP_W-1:0] op, int pos,
			logic [VAL_W-1:0] val, int reps, bit typed, logic [VAL_W-1:0] rd,
			status_t st, int cnt);
		dir_row_t r;
		r.op             = op;
		r.pos            = POS_W'(pos);
		r.val            = val;
		r.reps           = reps;
		r.typed          = typed;
		r.res.read_value = rd;
		r.res.status     = st;
		r.res.count      = CNT_W'(cnt);
		return r;
	endfunction

	function automatic logic [OP_W-1:0] pick_op(fill_mode_t mode);
		int r;
		r = $urandom_range(0, 99);
		if (r < 2) return OP_W'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
		if (r < 3) return OP_CLEAR;
		case (mode)
			MODE_GROW: begin
				if (r < 45) return OP_APPEND;
				if (r < 70) return OP_INSERT;
				if (r < 85) return OP_READ;
				if (r < 93) return OP_REMOVE;
				return OP_ERASE;
			end
			MODE_SHRINK: begin
				if (r < 12) return OP_APPEND;
				if (r < 22) return OP_INSERT;
				if (r < 42) return OP_READ;
				if (r < 70) return OP_REMOVE;
				return OP_ERASE;
			end
			default: begin
				if (r < 22) return OP_APPEND;
				if (r < 42) return OP_INSERT;
				if (r < 66) return OP_READ;
				if (r < 80) return OP_REMOVE;
				return OP_ERASE;
			end
		endcase
	endfunction

	// Mostly legal positions for the current fill, plus edges and raw bytes.
	function automatic logic signed [POS_W-1:0] pick_position(logic [OP_W-1:0] op);
		int n;
		int r;
		int p;
		n = list_vals.size();
		r = $urandom_range(0, 19);
		if (r == 0) return POS_W'($urandom_range(0, 255));
		if (r == 1) begin
			case ($urandom_range(0, 3))
				0: p = n;
				1: p = n + 1;
				2: p = -1;
				default: p = -n - 1;
			endcase
			return POS_W'(p);
		end
		if (op == OP_READ && n > 0 && r < 9) begin
			p = $urandom_range(1, n);
			return POS_W'(-p);
		end
		if (op == OP_INSERT) p = $urandom_range(0, n);
		else p = $urandom_range(0, (n > 0) ? n - 1 : 0);
		return POS_W'(p);
	endfunction

	function automatic logic signed [VAL_W-1:0] pick_value();
		case ($urandom_range(0, 15))
			0: return 32'sh7fffffff;
			1: return 32'sh80000000;
			default: return VAL_W'($urandom);
		endcase
	endfunction

	task automatic send_op(logic [OP_W-1:0] op, logic signed [POS_W-1:0] pos,
			logic signed [VAL_W-1:0] val, bit typed, list_result_t typed_res);
		list_result_t res;
		if (!no_idle && burst_left == 0 && $urandom_range(0, 5) == 0) begin
			req_if.valid <= 1'b0;
			repeat ($urandom_range(1, 15)) @(posedge clk);
		end
		req_if.valid     <= 1'b1;
		req_if.operation <= op;
		req_if.position  <= pos;
		req_if.value     <= val;
		@(posedge clk);
		while (!req_if.ready) @(posedge clk);
		res = apply_list_op(op, pos, val);
		result_q.push_back(typed ? typed_res : res);
		status_hits[res.status]++;
		if (list_vals.size() > peak_fill) peak_fill = list_vals.size();
		n_sent++;
		if (burst_left > 0) burst_left--;
	endtask

	task automatic wait_drained();
		req_if.valid <= 1'b0;
		while (result_q.size() != 0) @(posedge clk);
	endtask

	// Output side: short random stalls, one long hold-off on request.
	initial begin
		forever begin
			if (hold_long) begin
				rsp_if.ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
				hold_long = 1'b0;
			end else if (!no_idle && $urandom_range(0, 7) == 0) begin
				rsp_if.ready <= 1'b0;
				repeat ($urandom_range(1, 15)) @(posedge clk);
			end else begin
				rsp_if.ready <= 1'b1;
				@(posedge clk);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && rsp_if.valid && rsp_if.ready) begin
			if (result_q.size() == 0) begin
				err_cnt++;
				if (err_cnt <= MAX_REPORTS)
					$display("%0t ns: result with none pending: value %0d status %0d count %0d",
						$time, rsp_if.read_value, rsp_if.status, rsp_if.count);
			end else begin
				exp_res = result_q.pop_front();
				n_checked++;
				if (rsp_if.read_value !== exp_res.read_value) begin
					err_cnt++;
					if (err_cnt <= MAX_REPORTS)
						$display("%0t ns: read_value expected %0d, got %0d",
							$time, exp_res.read_value, rsp_if.read_value);
				end
				if (rsp_if.status !== exp_res.status) begin
					err_cnt++;
					if (err_cnt <= MAX_REPORTS)
						$display("%0t ns: status expected %0d, got %0d",
							$time, exp_res.status, rsp_if.status);
				end
				if (rsp_if.count !== exp_res.count) begin
					err_cnt++;
					if (err_cnt <= MAX_REPORTS)
						$display("%0t ns: count expected %0d, got %0d",
							$time, exp_res.count, rsp_if.count);
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles == QUIET_LIMIT) begin
			$display("%0t ns: no transfer for %0d cycles", $time, QUIET_LIMIT);
			$display("tb: errors");
			$finish;
		end
	end

	initial begin
		dir_row_t   dir_rows[$];
		dir_row_t   row;
		fill_mode_t mode;
		int         seg_left;
		logic [OP_W-1:0] op;

		arst_n           <= 1'b0;
		req_if.valid     <= 1'b0;
		req_if.operation <= OP_APPEND;
		req_if.position  <= '0;
		req_if.value     <= '0;
		foreach (status_hits[i]) status_hits[i] = 0;

		dir_rows = '{
			step_row(OP_REMOVE, 0, 0, 1, 1, 0, ST_EMPTY, 0),
			step_row(OP_READ, 0, 0, 1, 1, 0, ST_EMPTY, 0),
			step_row(OP_ERASE, 0, 0, 1, 1, 0, ST_EMPTY, 0),
			step_row(OP_INSERT, 1, 0, 1, 1, 0, ST_RANGE, 0),
			step_row(OP_INSERT, -1, 0, 1, 1, 0, ST_RANGE, 0),
			step_row(OP_APPEND, 0, 32'h7fffffff, 1, 1, 0, ST_OK, 1),
			step_row(OP_INSERT, 0, 32'h80000000, 1, 1, 0, ST_OK, 2),
			step_row(OP_READ, 0, 0, 1, 1, 32'h80000000, ST_OK, 2),
			step_row(OP_READ, -1, 0, 1, 1, 32'h7fffffff, ST_OK, 2),
			step_row(OP_READ, -3, 0, 1, 1, 0, ST_RANGE, 2),
			step_row(OP_READ, -128, 0, 1, 1, 0, ST_RANGE, 2),
			step_row(OP_READ, 127, 0, 1, 1, 0, ST_RANGE, 2),
			step_row(OP_ERASE, 2, 0, 1, 1, 0, ST_RANGE, 2),
			step_row(OP_ERASE, -1, 0, 1, 1, 0, ST_RANGE, 2),
			step_row(OP_INSERT, 2, 32'hffffffff, 1, 1, 0, ST_OK, 3),
			step_row(OP_ERASE, 0, 0, 1, 1, 0, ST_OK, 2),
			step_row(OP_UNUSED_LO, -1, 32'hffffffff, 1, 1, 0, ST_OK, 2),
			step_row(OP_UNUSED_HI, 127, 0, 1, 1, 0, ST_OK, 2),
			step_row(OP_REMOVE, 0, 0, 1, 1, 32'hffffffff, ST_OK, 1),
			step_row(OP_APPEND, 0, 0, DEPTH - 1, 0, 0, ST_OK, 0),
			step_row(OP_APPEND, 0, 32'h1, 1, 1, 0, ST_FULL, DEPTH),
			step_row(OP_INSERT, DEPTH, 0, 1, 1, 0, ST_FULL, DEPTH),
			step_row(OP_INSERT, DEPTH + 1, 0, 1, 1, 0, ST_RANGE, DEPTH),
			step_row(OP_READ, -DEPTH, 0, 1, 1, 32'h7fffffff, ST_OK, DEPTH),
			step_row(OP_ERASE, 0, 0, 1, 1, 0, ST_OK, DEPTH - 1),
			step_row(OP_INSERT, 0, 32'h5a5a5a5a, 1, 1, 0, ST_OK, DEPTH),
			step_row(OP_CLEAR, 0, 0, 1, 1, 0, ST_OK, 0)
		};

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		foreach (dir_rows[i]) begin
			row = dir_rows[i];
			repeat (row.reps)
				send_op(row.op, row.pos, (row.reps > 1) ? pick_value() : row.val,
					row.typed, row.res);
		end

		mode     = MODE_GROW;
		seg_left = 0;
		for (int k = 0; k < N_RANDOM; k++) begin
			if (seg_left == 0) begin
				case ($urandom_range(0, 3))
					0, 1: mode = MODE_GROW;
					2: mode = MODE_SHRINK;
					default: mode = MODE_MIXED;
				endcase
				seg_left = $urandom_range(60, 160);
			end
			seg_left--;
			// output held off while inputs keep coming back to back
			if (k == 300) begin
				hold_long  = 1'b1;
				burst_left = 40;
			end
			if (k == 600) wait_drained();
			if (k == N_RANDOM - 150) no_idle = 1'b1;
			op = pick_op(mode);
			send_op(op, pick_position(op), pick_value(), 1'b0, '0);
		end

		wait_drained();
		repeat (DEPTH + 20) @(posedge clk);

		$display("tb: %0d operations sent, %0d results checked, peak fill %0d of %0d",
			n_sent, n_checked, peak_fill, DEPTH);
		$display("tb: ok %0d, bad position %0d, full %0d, empty %0d; long stall, drain done",
			status_hits[ST_OK], status_hits[ST_RANGE], status_hits[ST_FULL],
			status_hits[ST_EMPTY]);
		if (err_cnt == 0)
			$display("tb: clean");
		else
			$display("tb: errors");
		$finish;
	end

endmodule

// ===== filelist.f =====
hw/rtl/bls_pkg.sv
hw/rtl/bls_if.sv
hw/rtl/bls_mem.sv
hw/rtl/bls_ctrl.sv
hw/rtl/bounded_list_store_unit.sv
hw/rtl/bls_chk.sv
verif/tb.sv
